/* design/p2r_pkg.sv */
// shared constants and tables for the polar to rectangular converter
`timescale 1ns / 1ps
`default_nettype none

package p2r_pkg;

  // fixed field widths
  localparam int MAG_W = 16;
  localparam int ANG_IN_W = 16;
  localparam int OUT_W = 16;

  // default build options
  localparam int ROTATION_STEPS_DEF = 16;
  localparam int DATA_WIDTH_DEF = 16;

  // output fraction bits (q8.8)
  localparam int OUT_FRAC = 8;

  // integer bits of the x/y datapath beyond the fraction bits, sign included
  localparam int INT_BITS = 10;

  // angle accumulator: 30 fraction bits, input is shifted up by 17
  localparam int ANGLE_W = 34;
  localparam int ANG_SHIFT = 17;
  localparam logic signed [ANGLE_W-1:0] ANG_PI = 34'sd3373259426;
  localparam logic signed [ANGLE_W-1:0] ANG_TWO_PI = 34'sd6746518852;
  localparam logic signed [ANGLE_W-1:0] ANG_HALF_PI = 34'sd1686629713;

  // cordic gain with 30 fraction bits
  localparam int GAIN_W = 31;
  localparam int GAIN_FRAC = 30;
  localparam logic signed [GAIN_W-1:0] GAIN_K = 31'sd652032874;
  localparam int PROD_W = MAG_W + GAIN_W;

  // atan(2^-i), 30 fraction bits, truncated
  localparam int ATAN_ENTRIES = 24;
  localparam int ATAN_W = 32;
  localparam logic [ATAN_W-1:0] ATAN_TABLE [ATAN_ENTRIES] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

endpackage

`default_nettype wire

/* design/p2r_in_if.sv */
// input channel: magnitude and angle beats
`timescale 1ns / 1ps
`default_nettype none

interface p2r_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [p2r_pkg::MAG_W-1:0]    magnitude;
  logic signed [p2r_pkg::ANG_IN_W-1:0] angle_rad;

  modport source (output valid, output magnitude, output angle_rad, input ready);
  modport sink (input valid, input magnitude, input angle_rad, output ready);
endinterface

`default_nettype wire

/* design/p2r_out_if.sv */
// output channel: rectangular component beats
`timescale 1ns / 1ps
`default_nettype none

interface p2r_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [p2r_pkg::OUT_W-1:0] x_part;
  logic signed [p2r_pkg::OUT_W-1:0] y_part;

  modport source (output valid, output x_part, output y_part, input ready);
  modport sink (input valid, input x_part, input y_part, output ready);
endinterface

`default_nettype wire

/* design/p2r_prep.sv */
// front stages: gain scaling, angle wrap and quadrant fold
`timescale 1ns / 1ps
`default_nettype none

module p2r_prep #(
  parameter int DATA_WIDTH = p2r_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  valid_i,
  output logic                                       ready_o,
  input  wire logic signed [p2r_pkg::MAG_W-1:0]      magnitude_i,
  input  wire logic signed [p2r_pkg::ANG_IN_W-1:0]   angle_i,
  output logic                                       valid_o,
  input  wire logic                                  ready_i,
  output logic signed [DATA_WIDTH+p2r_pkg::INT_BITS-1:0] x_o,
  output logic signed [p2r_pkg::ANGLE_W-1:0]         angle_o
);

  localparam int W = DATA_WIDTH + p2r_pkg::INT_BITS;
  localparam int AW = p2r_pkg::ANGLE_W;
  localparam int PW = p2r_pkg::PROD_W;
  localparam int Sh = p2r_pkg::OUT_FRAC + p2r_pkg::GAIN_FRAC - DATA_WIDTH;
  localparam logic signed [PW-1:0] RoundHalf = {{(PW-1){1'b0}}, 1'b1} << (Sh - 1);

  // stage one: product and wrapped angle
  logic                   v1_q;
  logic                   rdy1;
  logic signed [PW-1:0]   prod_d, prod_q;
  logic signed [AW-1:0]   ang_ext;
  logic signed [AW-1:0]   ang1_d, ang1_q;

  // stage two: rounded start value and folded angle
  logic                   v2_q;
  logic                   rdy2;
  logic signed [PW-1:0]   prod_rnd;
  logic signed [W-1:0]    x0;
  logic signed [W-1:0]    x2_d, x2_q;
  logic signed [AW-1:0]   ang2_d, ang2_q;

  assign prod_d = p2r_pkg::GAIN_K * magnitude_i;
  assign ang_ext = {{(AW - p2r_pkg::ANG_IN_W - p2r_pkg::ANG_SHIFT){angle_i[p2r_pkg::ANG_IN_W-1]}},
                    angle_i, {p2r_pkg::ANG_SHIFT{1'b0}}};

  always_comb begin
    if (ang_ext > p2r_pkg::ANG_PI) begin
      ang1_d = ang_ext - p2r_pkg::ANG_TWO_PI;
    end else if (ang_ext < -p2r_pkg::ANG_PI) begin
      ang1_d = ang_ext + p2r_pkg::ANG_TWO_PI;
    end else begin
      ang1_d = ang_ext;
    end
  end

  assign prod_rnd = (prod_q + RoundHalf) >>> Sh;
  assign x0 = prod_rnd[W-1:0];

  always_comb begin
    if (ang1_q > p2r_pkg::ANG_HALF_PI) begin
      ang2_d = ang1_q - p2r_pkg::ANG_PI;
      x2_d = -x0;
    end else if (ang1_q < -p2r_pkg::ANG_HALF_PI) begin
      ang2_d = ang1_q + p2r_pkg::ANG_PI;
      x2_d = -x0;
    end else begin
      ang2_d = ang1_q;
      x2_d = x0;
    end
  end

  assign rdy2 = !v2_q || ready_i;
  assign rdy1 = !v1_q || rdy2;
  assign ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      prod_q <= prod_d;
      ang1_q <= ang1_d;
    end
    if (rdy2 && v1_q) begin
      x2_q <= x2_d;
      ang2_q <= ang2_d;
    end
  end

  assign valid_o = v2_q;
  assign x_o = x2_q;
  assign angle_o = ang2_q;

endmodule

`default_nettype wire

/* design/p2r_cell.sv */
// one cordic rotation cell with its own pipeline register
`timescale 1ns / 1ps
`default_nettype none

module p2r_cell #(
  parameter int DATA_WIDTH = p2r_pkg::DATA_WIDTH_DEF,
  parameter int SHIFT = 0
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      valid_i,
  output logic                                           ready_o,
  input  wire logic signed [DATA_WIDTH+p2r_pkg::INT_BITS-1:0] x_i,
  input  wire logic signed [DATA_WIDTH+p2r_pkg::INT_BITS-1:0] y_i,
  input  wire logic signed [p2r_pkg::ANGLE_W-1:0]        angle_i,
  output logic                                           valid_o,
  input  wire logic                                      ready_i,
  output logic signed [DATA_WIDTH+p2r_pkg::INT_BITS-1:0] x_o,
  output logic signed [DATA_WIDTH+p2r_pkg::INT_BITS-1:0] y_o,
  output logic signed [p2r_pkg::ANGLE_W-1:0]             angle_o
);

  localparam int W = DATA_WIDTH + p2r_pkg::INT_BITS;
  localparam int AW = p2r_pkg::ANGLE_W;
  localparam logic signed [AW-1:0] Atan =
    {{(AW - p2r_pkg::ATAN_W){1'b0}}, p2r_pkg::ATAN_TABLE[SHIFT]};

  logic                 valid_q;
  logic                 rdy;
  logic signed [W-1:0]  xs, ys;
  logic signed [W-1:0]  x_d, x_q, y_d, y_q;
  logic signed [AW-1:0] a_d, a_q;

  assign xs = x_i >>> SHIFT;
  assign ys = y_i >>> SHIFT;

  // rotate toward zero residual angle
  always_comb begin
    if (!angle_i[AW-1]) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      a_d = angle_i - Atan;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      a_d = angle_i + Atan;
    end
  end

  assign rdy = !valid_q || ready_i;
  assign ready_o = rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rdy) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && valid_i) begin
      x_q <= x_d;
      y_q <= y_d;
      a_q <= a_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o = x_q;
  assign y_o = y_q;
  assign angle_o = a_q;

endmodule

`default_nettype wire

/* design/p2r_out.sv */
// output stage: round back to q8.8 and saturate
`timescale 1ns / 1ps
`default_nettype none

module p2r_out #(
  parameter int DATA_WIDTH = p2r_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      valid_i,
  output logic                                           ready_o,
  input  wire logic signed [DATA_WIDTH+p2r_pkg::INT_BITS-1:0] x_i,
  input  wire logic signed [DATA_WIDTH+p2r_pkg::INT_BITS-1:0] y_i,
  output logic                                           valid_o,
  input  wire logic                                      ready_i,
  output logic signed [p2r_pkg::OUT_W-1:0]               x_o,
  output logic signed [p2r_pkg::OUT_W-1:0]               y_o
);

  localparam int W = DATA_WIDTH + p2r_pkg::INT_BITS;
  localparam int OW = p2r_pkg::OUT_W;
  localparam int Fs = DATA_WIDTH - p2r_pkg::OUT_FRAC;
  localparam logic signed [W-1:0] RoundHalf = {{(W-1){1'b0}}, 1'b1} << (Fs - 1);
  localparam logic signed [W-1:0] SatHi = W'(32767);
  localparam logic signed [W-1:0] SatLo = -W'(32768);

  function automatic logic signed [OW-1:0] round_sat(input logic signed [W-1:0] v);
    logic signed [W-1:0] r;
    r = (v + RoundHalf) >>> Fs;
    if (r > SatHi) begin
      return SatHi[OW-1:0];
    end else if (r < SatLo) begin
      return SatLo[OW-1:0];
    end
    return r[OW-1:0];
  endfunction

  logic                 valid_q;
  logic                 rdy;
  logic signed [OW-1:0] x_q, y_q;

  assign rdy = !valid_q || ready_i;
  assign ready_o = rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rdy) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && valid_i) begin
      x_q <= round_sat(x_i);
      y_q <= round_sat(y_i);
    end
  end

  assign valid_o = valid_q;
  assign x_o = x_q;
  assign y_o = y_q;

endmodule

`default_nettype wire

/* design/polar_to_rectangular.sv */
// top level: pipelined cordic polar to rectangular converter
//
//   channel   dir   handshake      payload
//   in_ch_i   in    valid/ready    magnitude (s16 q8.8), angle_rad (s16 q3.13)
//   out_ch_o  out   valid/ready    x_part (s16 q8.8), y_part (s16 q8.8)
//
// one beat in, one beat out; a new beat can be taken every cycle while the output is not stalled
// pipeline: two front stages, one cell per rotation, one output stage
// (the step count is capped at the 24-entry arctangent table)
// every stage has its own valid bit and moves when the next one is free, so
// bubbles close up and input is still taken while a finished beat waits
// reset clears only the valid bits; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module polar_to_rectangular #(
  parameter int ROTATION_STEPS = p2r_pkg::ROTATION_STEPS_DEF,
  parameter int DATA_WIDTH = p2r_pkg::DATA_WIDTH_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  p2r_in_if.sink      in_ch_i,
  p2r_out_if.source   out_ch_o
);

  // datapath width: DATA_WIDTH fraction bits plus integer headroom
  localparam int W = DATA_WIDTH + p2r_pkg::INT_BITS;
  localparam int AW = p2r_pkg::ANGLE_W;
  // rotations beyond the table are not done
  localparam int Steps = (ROTATION_STEPS > p2r_pkg::ATAN_ENTRIES) ?
                         p2r_pkg::ATAN_ENTRIES : ROTATION_STEPS;

  // links between neighbors in the cell chain; link 0 is the front stage output
  logic                 link_valid [Steps+1];
  logic                 link_ready [Steps+1];
  logic signed [W-1:0]  link_x     [Steps+1];
  logic signed [W-1:0]  link_y     [Steps+1];
  logic signed [AW-1:0] link_a     [Steps+1];

  // gain scaling, angle wrap into [-pi, pi], fold into [-pi/2, pi/2]
  p2r_prep #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_ch_i.valid),
    .ready_o     (in_ch_i.ready),
    .magnitude_i (in_ch_i.magnitude),
    .angle_i     (in_ch_i.angle_rad),
    .valid_o     (link_valid[0]),
    .ready_i     (link_ready[0]),
    .x_o         (link_x[0]),
    .angle_o     (link_a[0])
  );

  // rotation starts on the x axis
  assign link_y[0] = '0;

  // one cell per rotation, each shifting by its own index
  for (genvar i = 0; i < Steps; i++) begin : g_cell
    p2r_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .SHIFT      (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (link_valid[i]),
      .ready_o (link_ready[i]),
      .x_i     (link_x[i]),
      .y_i     (link_y[i]),
      .angle_i (link_a[i]),
      .valid_o (link_valid[i+1]),
      .ready_i (link_ready[i+1]),
      .x_o     (link_x[i+1]),
      .y_o     (link_y[i+1]),
      .angle_o (link_a[i+1])
    );
  end

  // round half up to q8.8 and clamp to the 16-bit range
  p2r_out #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (link_valid[Steps]),
    .ready_o (link_ready[Steps]),
    .x_i     (link_x[Steps]),
    .y_i     (link_y[Steps]),
    .valid_o (out_ch_o.valid),
    .ready_i (out_ch_o.ready),
    .x_o     (out_ch_o.x_part),
    .y_o     (out_ch_o.y_part)
  );

endmodule

`default_nettype wire

/* test/tb.sv */
// testbench for the polar to rectangular converter: fixed-point prediction and scoreboard
`timescale 1ns / 1ps

module tb;
  import p2r_pkg::*;

  localparam int STEPS = ROTATION_STEPS_DEF;
  localparam int DW = DATA_WIDTH_DEF;
  localparam int LATENCY = ((STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : STEPS) + 3;
  // cycles with no beat moving on either side before the run is declared hung
  localparam int STALL_LIMIT = 2000;

  // angle codes in q3.13
  localparam int ANG_Q_PI = 25736;      // just above pi, wraps
  localparam int ANG_Q_PI_LO = 25735;   // just below pi
  localparam int ANG_Q_HALF = 12868;    // about pi/2
  localparam int ANG_Q_QUARTER = 6434;  // about pi/4

  // one expected result together with the input that caused it
  typedef struct {
    logic signed [MAG_W-1:0]    magnitude;
    logic signed [ANG_IN_W-1:0] angle_rad;
    logic signed [OUT_W-1:0]    x_part;
    logic signed [OUT_W-1:0]    y_part;
  } rect_beat_t;

  logic clk;
  logic rst_n;

  p2r_in_if  in_ch ();
  p2r_out_if out_ch ();

  polar_to_rectangular #(
    .ROTATION_STEPS(STEPS),
    .DATA_WIDTH    (DW)
  ) uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_ch_i (in_ch),
    .out_ch_o(out_ch)
  );

  rect_beat_t expected_rect_q[$];
  int         mismatch_count = 0;
  bit         quiet_mode = 1'b0;   // no gaps on the sender, no stalls on the receiver
  int         burst_left = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // add half an lsb, then floor
  function automatic longint round_half_up(input longint v, input int s);
    if (s == 0) return v;
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [OUT_W-1:0] clip_q88(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[OUT_W-1:0];
  endfunction

  function automatic rect_beat_t rotate_polar(input logic signed [MAG_W-1:0] mag,
                                              input logic signed [ANG_IN_W-1:0] ang);
    longint     acc_x;
    longint     acc_y;
    longint     acc_a;
    longint     sh_x;
    longint     sh_y;
    longint     atan_i;
    longint     pi_l;
    longint     half_pi_l;
    int         n_steps;
    rect_beat_t r;
    pi_l = longint'(ANG_PI);
    half_pi_l = longint'(ANG_HALF_PI);
    n_steps = (STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : STEPS;
    // gain-compensated start vector on the x axis
    acc_x = round_half_up(longint'(mag) * longint'(GAIN_K), GAIN_FRAC + OUT_FRAC - DW);
    acc_y = 0;
    acc_a = longint'(ang) <<< ANG_SHIFT;
    // one wrap by 2*pi
    if (acc_a > pi_l) acc_a = acc_a - 2 * pi_l;
    else if (acc_a < -pi_l) acc_a = acc_a + 2 * pi_l;
    // fold the outer quadrants in, flipping the start vector
    if (acc_a > half_pi_l) begin
      acc_a = acc_a - pi_l;
      acc_x = -acc_x;
    end else if (acc_a < -half_pi_l) begin
      acc_a = acc_a + pi_l;
      acc_x = -acc_x;
    end
    for (int i = 0; i < n_steps; i++) begin
      sh_x = acc_x >>> i;
      sh_y = acc_y >>> i;
      atan_i = longint'({32'd0, ATAN_TABLE[i]});
      if (acc_a >= 0) begin
        acc_x = acc_x - sh_y;
        acc_y = acc_y + sh_x;
        acc_a = acc_a - atan_i;
      end else begin
        acc_x = acc_x + sh_y;
        acc_y = acc_y - sh_x;
        acc_a = acc_a + atan_i;
      end
    end
    r.magnitude = mag;
    r.angle_rad = ang;
    r.x_part = clip_q88(round_half_up(acc_x, DW - OUT_FRAC));
    r.y_part = clip_q88(round_half_up(acc_y, DW - OUT_FRAC));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // reporting and checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input rect_beat_t want,
                                 input logic signed [OUT_W-1:0] got);
    mismatch_count++;
    $display("MISMATCH %s: mag=%0d ang=%0d got=%0d want x=%0d y=%0d",
             what, want.magnitude, want.angle_rad, got, want.x_part, want.y_part);
  endtask

  // compare each result beat with the oldest pending prediction
  initial begin : rect_checker
    rect_beat_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_rect_q.size() == 0) begin
          want = '{default: '0};
          report_mismatch("unexpected beat", want, out_ch.x_part);
        end else begin
          want = expected_rect_q.pop_front();
          if (out_ch.x_part !== want.x_part) report_mismatch("x_part", want, out_ch.x_part);
          if (out_ch.y_part !== want.y_part) report_mismatch("y_part", want, out_ch.y_part);
        end
      end
    end
  end

  // receiver back-pressure: runs of always ready, coin flips, mostly ready, or long stalls
  initial begin : sink_pattern
    int mode;
    int run;
    out_ch.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      run = $urandom_range(1, 40);
      repeat (run) begin
        @(posedge clk);
        if (quiet_mode) out_ch.ready <= 1'b1;
        else begin
          case (mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 1) == 1);
            2: out_ch.ready <= 1'b0;
            default: out_ch.ready <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  // hang detection: nothing moving on either channel for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // offer one beat, wait for it to be taken, then maybe pause between bursts
  task automatic send_polar(input logic signed [MAG_W-1:0] mag,
                            input logic signed [ANG_IN_W-1:0] ang);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.magnitude <= mag;
    in_ch.angle_rad <= ang;
    do @(posedge clk); while (!in_ch.ready);
    expected_rect_q.push_back(rotate_polar(mag, ang));
    if (!quiet_mode) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // unit vector on the axes and the diagonal, plus zero and one-lsb magnitudes
  task automatic test_axis_points();
    send_polar(16'sd256, 16'sd0);
    send_polar(16'sd256, 16'(ANG_Q_HALF));
    send_polar(16'sd256, -16'(ANG_Q_HALF));
    send_polar(16'sd256, 16'(ANG_Q_QUARTER));
    send_polar(16'sd0, 16'sh7fff);
    send_polar(16'sd1, 16'sd0);
    send_polar(-16'sd1, 16'sd0);
  endtask

  // full-scale magnitudes, including the +128.0 result that must saturate
  task automatic test_full_scale();
    send_polar(16'sh7fff, 16'sd0);
    send_polar(16'sh8000, 16'sd0);
    send_polar(16'sh7fff, 16'(ANG_Q_HALF));
    send_polar(16'sh8000, -16'(ANG_Q_HALF));
    send_polar(16'sh8000, 16'(ANG_Q_PI_LO));
    send_polar(16'sh7fff, 16'(ANG_Q_PI_LO));
  endtask

  // angles past pi in both directions get one 2*pi correction
  task automatic test_angle_wrap();
    send_polar(16'sd1000, 16'(ANG_Q_PI));
    send_polar(16'sd1000, -16'(ANG_Q_PI));
    send_polar(16'sd1000, 16'sh7fff);
    send_polar(-16'sd1000, 16'sh8000);
    send_polar(16'sh8000, 16'sh8000);
  endtask

  // both sides of the quadrant fold at plus and minus pi/2
  task automatic test_quadrant_fold();
    send_polar(16'sd5000, 16'(ANG_Q_HALF + 1));
    send_polar(16'sd5000, 16'(ANG_Q_HALF - 1));
    send_polar(16'sd5000, -16'(ANG_Q_HALF + 1));
    send_polar(16'sd5000, -16'(ANG_Q_HALF - 1));
    send_polar(-16'sd5000, 16'sd20000);
    send_polar(-16'sd5000, -16'sd20000);
  endtask

  // uniform over both fields, with gaps and stalls
  task automatic test_random_span(input int n);
    repeat (n) send_polar(16'($urandom), 16'($urandom));
  endtask

  // back-to-back beats with the receiver always ready
  task automatic test_random_streaming(input int n);
    quiet_mode = 1'b1;
    repeat (n) send_polar(16'($urandom), 16'($urandom));
    quiet_mode = 1'b0;
  endtask

  // angles clustered on zero, the wrap and fold points and the ends of the code range, magnitudes often near full scale
  task automatic test_random_boundaries(input int n);
    int base;
    int ang;
    int mag;
    repeat (n) begin
      case ($urandom_range(0, 6))
        0: base = 0;
        1: base = ANG_Q_HALF;
        2: base = -ANG_Q_HALF;
        3: base = ANG_Q_PI;
        4: base = -ANG_Q_PI;
        5: base = 32767;
        default: base = -32768;
      endcase
      ang = base + $urandom_range(0, 64) - 32;
      case ($urandom_range(0, 2))
        0: mag = 32767 - $urandom_range(0, 16);
        1: mag = -32768 + $urandom_range(0, 16);
        default: mag = int'($urandom);
      endcase
      send_polar(16'(mag), 16'(ang));
    end
  endtask

  initial begin : main
    in_ch.valid <= 1'b0;
    in_ch.magnitude <= '0;
    in_ch.angle_rad <= '0;
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_axis_points();
    test_full_scale();
    test_angle_wrap();
    test_quadrant_fold();
    test_random_span(500);
    test_random_streaming(200);
    test_random_boundaries(300);

    in_ch.valid <= 1'b0;
    // drain, then give any stray beat time to show up
    while (expected_rect_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
